// ===== rtl/core/pfa_pkg.sv =====
// Package for the partition fit allocator.
// Holds shared constants, policy and register codes, the FSM type and the cell control struct.
// No dependencies.
package pfa_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int SIZE_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;   // width of amount and size fields on the ports
    localparam int SLOT_BITS     = 4;    // width of slot fields on the ports
    localparam int POL_BITS      = 2;
    localparam int CNT_BITS      = 5;    // width of the slots_in_use register
    localparam int ADDR_BITS     = 3;

    localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_BITS-1:0] POL_WORST = 2'd1;
    localparam logic [POL_BITS-1:0] POL_BEST  = 2'd2;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLOTS  = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // broadcast controls seen by every cell
    typedef struct packed {
        logic                ld_en;
        logic                wb_en;
        logic [POL_BITS-1:0] policy;
    } t_cell_ctl;

endpackage

// ===== rtl/core/pfa_cell.sv =====
// One slot of the allocator chain: holds a free size and updates the passing scan token.
// Depends on pfa_pkg.
module pfa_cell
    import pfa_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IW        = 4,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [CNT_BITS-1:0]  i_slots_in_use,
    input  logic [SLOT_BITS-1:0] i_ld_slot,
    input  logic [SIZE_BITS-1:0] i_ld_data,
    input  logic [IW-1:0]        i_wb_slot,
    input  logic [SIZE_BITS-1:0] i_amount,
    input  logic                 i_tk_valid,
    input  logic                 i_tk_have,
    input  logic [IW-1:0]        i_tk_pick,
    input  logic [SIZE_BITS-1:0] i_tk_best,
    output logic                 o_tk_valid,
    output logic                 o_tk_have,
    output logic [IW-1:0]        o_tk_pick,
    output logic [SIZE_BITS-1:0] o_tk_best
);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_tk_valid;
    logic                 r_tk_have;
    logic [IW-1:0]        r_tk_pick;
    logic [SIZE_BITS-1:0] r_tk_best;

    logic w_in_use;
    logic w_fit;
    logic w_take;

    assign w_in_use = (IDX < int'(i_slots_in_use));
    assign w_fit    = w_in_use && (r_size >= i_amount);

    always_comb begin
        w_take = 1'b0;
        if (w_fit) begin
            if (!i_tk_have) begin
                w_take = 1'b1;
            end else begin
                case (i_ctl.policy)
                    POL_WORST: w_take = (r_size > i_tk_best);
                    POL_BEST:  w_take = (r_size < i_tk_best);
                    default:   w_take = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_ctl.ld_en && (int'(i_ld_slot) == IDX)) begin
            r_size <= i_ld_data;
        end else if (i_ctl.wb_en && (i_wb_slot == IW'(IDX))) begin
            r_size <= r_size - i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk_valid <= 1'b0;
        end else begin
            r_tk_valid <= i_tk_valid;
        end
    end

    // token payload holds between scans so the tail stays readable while the result waits
    always_ff @(posedge i_clk) begin
        if (i_tk_valid) begin
            r_tk_have <= i_tk_have || w_fit;
            r_tk_pick <= w_take ? IW'(IDX) : i_tk_pick;
            r_tk_best <= w_take ? r_size : i_tk_best;
        end
    end

    assign o_tk_valid = r_tk_valid;
    assign o_tk_have  = r_tk_have;
    assign o_tk_pick  = r_tk_pick;
    assign o_tk_best  = r_tk_best;

endmodule

// ===== rtl/core/partition_fit_allocator.sv =====
// Partition fit allocator: first, worst or best fit over a chain of slot cells.
// Load: accepted with no result. Request: registered as a start strobe, after which the scan
// token walks the cell chain one slot per cycle, then writes back.
// One item at a time: a request holds the input through its scan, longer while its result
// waits for the output register; loads go one per cycle when idle. Reset (synchronous,
// active low) clears all slot sizes, policy and slots_in_use to zero. Uses pfa_pkg, pfa_cell.
module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [FIELD_BITS-1:0] i_amount,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_found,
    output logic [SLOT_BITS-1:0]  o_chosen_slot,
    output logic [FIELD_BITS-1:0] o_size_before,
    output logic [FIELD_BITS-1:0] o_size_after
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state r_state, n_state;

    logic [POL_BITS-1:0]   r_policy;
    logic [CNT_BITS-1:0]   r_slots_in_use;
    logic [SIZE_BITS-1:0]  r_amount;
    logic                  r_start;

    logic                  r_out_valid;
    logic                  r_found;
    logic [SLOT_BITS-1:0]  r_chosen_slot;
    logic [FIELD_BITS-1:0] r_size_before;
    logic [FIELD_BITS-1:0] r_size_after;

    logic                  w_in_accept;
    logic                  w_cfg_wr;
    logic                  w_out_free;
    logic                  w_finish;
    logic [SIZE_BITS-1:0]  w_in_amount;
    logic [SIZE_BITS-1:0]  w_after;
    t_cell_ctl             w_ctl;

    logic                  w_tk_valid [SLOTS+1];
    logic                  w_tk_have  [SLOTS+1];
    logic [IW-1:0]         w_tk_pick  [SLOTS+1];
    logic [SIZE_BITS-1:0]  w_tk_best  [SLOTS+1];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy       <= POL_FIRST;
            r_slots_in_use <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_POLICY: r_policy       <= pwdata[POL_BITS-1:0];
                REG_SLOTS:  r_slots_in_use <= pwdata[CNT_BITS-1:0];
                default:    r_policy       <= r_policy;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POLICY: prdata = 32'(r_policy);
            REG_SLOTS:  prdata = 32'(r_slots_in_use);
            default:    prdata = '0;
        endcase
    end

    // handshake and sequencing
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_in_amount = SIZE_BITS'(i_amount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_in_accept && (i_kind == KIND_REQ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && (i_kind == KIND_REQ)) begin
            r_amount <= w_in_amount;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_accept && (i_kind == KIND_REQ)) n_state = ST_SCAN;
            ST_SCAN: if (w_tk_valid[SLOTS]) n_state = w_out_free ? ST_IDLE : ST_WAIT;
            ST_WAIT: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: w_finish   = w_tk_valid[SLOTS] && w_out_free;
            ST_WAIT: w_finish   = w_out_free;
            default: w_finish   = 1'b0;
        endcase
    end

    assign w_ctl.ld_en  = w_in_accept && (i_kind == KIND_LOAD);
    assign w_ctl.wb_en  = w_finish && w_tk_have[SLOTS];
    assign w_ctl.policy = r_policy;

    // cell chain
    assign w_tk_valid[0] = r_start;
    assign w_tk_have[0]  = 1'b0;
    assign w_tk_pick[0]  = '0;
    assign w_tk_best[0]  = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pfa_cell #(
            .IDX       (g),
            .IW        (IW),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_slots_in_use (r_slots_in_use),
            .i_ld_slot      (i_slot),
            .i_ld_data      (w_in_amount),
            .i_wb_slot      (w_tk_pick[SLOTS]),
            .i_amount       (r_amount),
            .i_tk_valid     (w_tk_valid[g]),
            .i_tk_have      (w_tk_have[g]),
            .i_tk_pick      (w_tk_pick[g]),
            .i_tk_best      (w_tk_best[g]),
            .o_tk_valid     (w_tk_valid[g+1]),
            .o_tk_have      (w_tk_have[g+1]),
            .o_tk_pick      (w_tk_pick[g+1]),
            .o_tk_best      (w_tk_best[g+1])
        );
    end

    // output register
    assign w_after = w_tk_best[SLOTS] - r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_found       <= w_tk_have[SLOTS];
            r_chosen_slot <= w_tk_have[SLOTS] ? SLOT_BITS'(w_tk_pick[SLOTS]) : '0;
            r_size_before <= w_tk_have[SLOTS] ? FIELD_BITS'(w_tk_best[SLOTS]) : '0;
            r_size_after  <= w_tk_have[SLOTS] ? FIELD_BITS'(w_after) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_chosen_slot = r_chosen_slot;
    assign o_size_before = r_size_before;
    assign o_size_after  = r_size_after;

    // checks
    a_no_ld_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ld_en && w_ctl.wb_en))
        else $error("load and writeback in the same cycle");

    a_req_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_kind == KIND_REQ)) |=> (r_state == ST_SCAN))
        else $error("request transfer did not start a scan");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tk_valid[SLOTS] |-> (r_state == ST_SCAN))
        else $error("scan token reached chain end outside a scan");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> o_out_valid)
        else $error("finished request left no result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            (o_chosen_slot == '0 && o_size_before == '0 && o_size_after == '0))
        else $error("not-found result carries nonzero fields");

endmodule

// ===== tb/pfa_fit_checker.sv =====
`timescale 1ns / 100ps
// Checker for partition_fit_allocator: tracks the register writes and the slot size table,
// predicts each allocation result and compares it with what leaves the block. Uses pfa_pkg.
module pfa_fit_checker
    import pfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_kind,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [FIELD_BITS-1:0] i_amount,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_found,
    input  logic [SLOT_BITS-1:0]  i_chosen_slot,
    input  logic [FIELD_BITS-1:0] i_size_before,
    input  logic [FIELD_BITS-1:0] i_size_after,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic                  found;
        logic [SLOT_BITS-1:0]  slot;
        logic [FIELD_BITS-1:0] prior;
        logic [FIELD_BITS-1:0] after;
    } t_alloc;

    logic [FIELD_BITS-1:0] free_size [SLOTS_DEF];
    logic [POL_BITS-1:0]   fit_policy;
    logic [CNT_BITS-1:0]   active_slots;
    t_alloc                alloc_q[$];
    int                    fail_cnt = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // picks a slot for the request and takes the amount out of it
    function automatic t_alloc allocate(input logic [FIELD_BITS-1:0] req);
        t_alloc r;
        int     lim;
        int     pick;
        bit     have;
        r    = '0;
        have = 1'b0;
        pick = 0;
        lim  = (active_slots > SLOTS_DEF) ? SLOTS_DEF : int'(active_slots);
        for (int i = 0; i < lim; i++) begin
            if (free_size[i] >= req) begin
                if (!have) begin
                    have = 1'b1;
                    pick = i;
                    // anything but worst or best (including the unused code) is first fit
                    if (fit_policy != POL_WORST && fit_policy != POL_BEST)
                        break;
                end else if (fit_policy == POL_WORST && free_size[i] > free_size[pick]) begin
                    pick = i;
                end else if (fit_policy == POL_BEST && free_size[i] < free_size[pick]) begin
                    pick = i;
                end
            end
        end
        if (have) begin
            r.found  = 1'b1;
            r.slot   = pick[SLOT_BITS-1:0];
            r.prior  = free_size[pick];
            r.after  = free_size[pick] - req;
            free_size[pick] = r.after;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_alloc want;
        if (!i_rst_n) begin
            foreach (free_size[i])
                free_size[i] = '0;
            fit_policy   = POL_FIRST;
            active_slots = '0;
            alloc_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_BITS-1:2])
                    REG_POLICY: fit_policy   = pwdata[POL_BITS-1:0];
                    REG_SLOTS:  active_slots = pwdata[CNT_BITS-1:0];
                    default: ;
                endcase
            end
            // results leave before a new request can be queued in the same cycle
            if (i_out_valid && i_out_ready) begin
                if (alloc_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending (found %0b slot %0d)",
                                              i_found, i_chosen_slot));
                end else begin
                    want = alloc_q.pop_front();
                    if (i_found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b", i_found, want.found));
                    if (i_chosen_slot !== want.slot)
                        report_mismatch($sformatf("chosen_slot %0d, want %0d",
                                                  i_chosen_slot, want.slot));
                    if (i_size_before !== want.prior)
                        report_mismatch($sformatf("size_before %08h, want %08h",
                                                  i_size_before, want.prior));
                    if (i_size_after !== want.after)
                        report_mismatch($sformatf("size_after %08h, want %08h",
                                                  i_size_after, want.after));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_LOAD)
                    free_size[i_slot] = i_amount;
                else
                    alloc_q = {alloc_q, allocate(i_amount)};
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= alloc_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the partition_fit_allocator testbench: clock, reset, register writes, load and
// request traffic with random idling, and the verdict. Uses pfa_pkg and pfa_fit_checker.
module testbench;
    import pfa_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = SLOTS_DEF + 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam logic [POL_BITS-1:0] POL_UNDEF = 2'd3;   // unused code, behaves as first fit

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]  paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind      = KIND_LOAD;
    logic [SLOT_BITS-1:0]  i_slot      = '0;
    logic [FIELD_BITS-1:0] i_amount    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [SLOT_BITS-1:0]  o_chosen_slot;
    logic [FIELD_BITS-1:0] o_size_before;
    logic [FIELD_BITS-1:0] o_size_after;

    int fail_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_slots    = 0;
    int items_sent     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    bit long_hold_req  = 1'b0;

    // last size loaded per slot, used to aim requests at exact fits
    logic [FIELD_BITS-1:0] recent_size [SLOTS_DEF];

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    partition_fit_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_chosen_slot (o_chosen_slot),
        .o_size_before (o_size_before),
        .o_size_after  (o_size_after)
    );

    pfa_fit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_found       (o_found),
        .i_chosen_slot (o_chosen_slot),
        .i_size_before (o_size_before),
        .i_size_after  (o_size_after),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("partition_fit_allocator test failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [SLOT_BITS-1:0] slot,
                             input logic [FIELD_BITS-1:0] amount);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_slot     <= slot;
        i_amount   <= amount;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (kind == KIND_LOAD)
            recent_size[slot] = amount;
        items_sent++;
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, let every result out, then give the block time to settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [POL_BITS-1:0] pol, input int slots,
                               input int send_pct, input int recv_pct);
        wait_drained();
        apb_write(REG_POLICY, 32'(pol));
        apb_write(REG_SLOTS, 32'(slots));
        phase_slots    = slots;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // 0: small multiples (lots of ties), 1: full range, 2: edge values
    function automatic logic [FIELD_BITS-1:0] pick_size(input int regime);
        case (regime)
            0: return FIELD_BITS'($urandom_range(8) * 16);
            1: return $urandom();
            default: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return FIELD_BITS'(1);
                    default: return ~FIELD_BITS'(1);
                endcase
            end
        endcase
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_request(input int regime);
        int r;
        r = $urandom_range(99);
        if (r < 40) return recent_size[$urandom_range(SLOTS_DEF-1)];
        if (r < 65) return FIELD_BITS'($urandom_range(150));
        if (r < 75) return $urandom();
        if (r < 85) return '0;
        if (r < 92) return '1;
        return pick_size(regime);
    endfunction

    task automatic run_traffic(input int count);
        int                   target;
        int                   regime;
        int                   lim;
        logic [SLOT_BITS-1:0] s;
        target = items_sent + count;
        lim    = (phase_slots > SLOTS_DEF) ? SLOTS_DEF : phase_slots;
        while (items_sent < target) begin
            if ($urandom_range(99) < 85) begin
                // fill a few slots, mostly ones in use, then allocate against them
                regime = $urandom_range(2);
                repeat ($urandom_range(6, 1)) begin
                    if (lim > 0 && $urandom_range(3) != 0)
                        s = SLOT_BITS'($urandom_range(lim - 1));
                    else
                        s = SLOT_BITS'($urandom_range(SLOTS_DEF - 1));
                    send_item(KIND_LOAD, s, pick_size(regime));
                end
                repeat ($urandom_range(4, 1))
                    send_item(KIND_REQ, SLOT_BITS'($urandom_range(15)), pick_request(regime));
            end else begin
                send_item(1'($urandom_range(1)), SLOT_BITS'($urandom_range(15)), $urandom());
            end
        end
    endtask

    initial begin
        logic [POL_BITS-1:0] pol_order [4];
        int                  slot_order [PHASES];
        pol_order  = '{POL_FIRST, POL_WORST, POL_BEST, POL_UNDEF};
        slot_order = '{16, 1, 31, 12, 17, 16, 0, 5};
        slot_order[6] = $urandom_range(31);
        foreach (recent_size[i])
            recent_size[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: no slots in use, so even a zero request misses
        send_item(KIND_REQ, 4'd0, '0);
        send_item(KIND_LOAD, 4'd15, '1);
        send_item(KIND_REQ, 4'd15, '1);

        // unused policy code acts as first fit; a slot count above 16 covers all 16 slots
        start_phase(POL_UNDEF, 31, 0, 0);
        send_item(KIND_LOAD, 4'd0, 32'd5);
        send_item(KIND_LOAD, 4'd1, '1);
        send_item(KIND_LOAD, 4'd2, 32'd5);
        send_item(KIND_LOAD, 4'd7, '0);
        send_item(KIND_REQ, 4'd3, '1);       // drains slot 1 to zero
        send_item(KIND_REQ, 4'd0, '0);       // zero request, lowest slot
        send_item(KIND_REQ, 4'd9, 32'd6);    // only slot 15 is big enough
        send_item(KIND_REQ, 4'd0, 32'd5);

        // worst fit with a three-way tie
        start_phase(POL_WORST, 16, 0, 0);
        send_item(KIND_LOAD, 4'd3, 32'd200);
        send_item(KIND_LOAD, 4'd4, 32'd200);
        send_item(KIND_LOAD, 4'd15, 32'd200);
        send_item(KIND_REQ, 4'd0, 32'd1);
        send_item(KIND_REQ, 4'd0, 32'd200);

        // best fit: exact fit, then zero request on an empty slot
        start_phase(POL_BEST, 16, 0, 0);
        send_item(KIND_REQ, 4'd0, 32'd5);
        send_item(KIND_REQ, 4'd0, '0);

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: start_phase(pol_order[0], slot_order[p], 0, 0);
                1: start_phase(pol_order[1], slot_order[p], 78, 0);
                2: start_phase(pol_order[2], slot_order[p], 0, 78);
                default: start_phase(pol_order[3], slot_order[p], 37, 37);
            endcase
            if (p >= 4)
                pol_order.shuffle();
            // the output side backs up and the block has to stall its input
            if (p == 0)
                long_hold_req = 1'b1;
            run_traffic(PHASE_ITEMS);
        end

        wait_drained();
        if (fail_count == 0 && pending_count == 0) begin
            $display("partition_fit_allocator test passed");
        end else begin
            $display("partition_fit_allocator test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/partition_fit_allocator.sv
tb/pfa_fit_checker.sv
tb/testbench.sv
